// File: design/min_gap_slot_reservation_table_defines.svh
// Assertion macros for the slot reservation table checker.
`ifndef MIN_GAP_SLOT_RESERVATION_TABLE_DEFINES_SVH
`define MIN_GAP_SLOT_RESERVATION_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MGSRT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slot table check failed");

// Next-cycle implication, disabled during reset.
`define MGSRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slot table check failed");

`endif

// File: design/mgsrt_pkg.sv
package mgsrt_pkg;

  localparam int TABLE_DEPTH = 32;

  localparam int ACT_W  = 2;
  localparam int TIME_W = 16;
  localparam int ID_W   = 16;
  localparam int STAT_W = 3;

  localparam logic [TIME_W-1:0] SEP_RESET = 16'd3;

  localparam logic [ACT_W-1:0] ACT_REQUEST  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WITHDRAW = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LIST     = 2'd2;

  localparam logic [STAT_W-1:0] ST_ADMITTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_REJECTED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_WITHDRAWN = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND  = 3'd4;
  localparam logic [STAT_W-1:0] ST_ENTRY     = 3'd5;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd6;

  // write data source for the table
  localparam logic [1:0] WSRC_NEW   = 2'd0;
  localparam logic [1:0] WSRC_CARRY = 2'd1;
  localparam logic [1:0] WSRC_MEMQ  = 2'd2;

  typedef struct packed {
    logic              take_item;
    logic              rd_next;
    logic              wr_en;
    logic              wr_prev;
    logic [1:0]        wr_src;
    logic              carry_load;
    logic              prev_load;
    logic              cnt_inc;
    logic              cnt_dec;
    logic              res_load;
    logic [STAT_W-1:0] res_code;
    logic              out_load;
    logic              out_entry;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic at_end;
    logic is_last;
    logic le_t;
    logic eq_t;
    logic gap_prev_fail;
    logic gap_next_fail;
    logic out_free;
  } stat_t;

endpackage

// File: design/mgsrt_if.sv
interface mgsrt_in_if;
  logic                          valid;
  logic                          ready;
  logic [mgsrt_pkg::ACT_W-1:0]   action;
  logic [mgsrt_pkg::TIME_W-1:0]  slot_time;
  logic [mgsrt_pkg::ID_W-1:0]    slot_id;

  modport source (output valid, action, slot_time, slot_id, input ready);
  modport sink   (input valid, action, slot_time, slot_id, output ready);
endinterface

interface mgsrt_out_if;
  logic                          valid;
  logic                          ready;
  logic [mgsrt_pkg::STAT_W-1:0]  status;
  logic [mgsrt_pkg::TIME_W-1:0]  out_time;
  logic [mgsrt_pkg::ID_W-1:0]    out_id;
  logic                          last;

  modport source (output valid, status, out_time, out_id, last, input ready);
  modport sink   (input valid, status, out_time, out_id, last, output ready);
endinterface

// File: design/min_gap_slot_reservation_table.sv
// Channel   Dir  Payload                                  Transfer
// in_ch     in   action, slot_time, slot_id               valid & ready
// out_ch    out  status, out_time, out_id, last           valid & ready
// cfg_*     in   cfg_wr_data -> min_separation            cfg_wr_en
//
// Sequence: request and withdraw scan, then shift where needed, then respond;
//   a request on a full table goes straight to the response; a list reads
//   its entries in order. The single table read port serialises these steps.
// Reset: rst_n synchronous, active low; no clearing pass, only entries below
//   the count are ever read.
// Stalls: out_ch.ready low holds the output register; a list pauses on the
//   current entry, other items wait in the response state.
module min_gap_slot_reservation_table #(
  parameter int TABLE_DEPTH = mgsrt_pkg::TABLE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  mgsrt_in_if.sink                       in_ch,
  mgsrt_out_if.source                    out_ch,
  input  logic                           cfg_wr_en,
  input  logic [mgsrt_pkg::TIME_W-1:0]   cfg_wr_data
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  mgsrt_pkg::cmd_t  cmd;
  mgsrt_pkg::stat_t stat;
  logic [CW-1:0]    idx;

  // sequencer: one item at a time, walks the table index
  mgsrt_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .stat      (stat),
    .idx       (idx),
    .cmd       (cmd)
  );

  // table memory, gap compare, count and output register
  mgsrt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_slot_time (in_ch.slot_time),
    .in_slot_id   (in_ch.slot_id),
    .idx          (idx),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_status   (out_ch.status),
    .out_time     (out_ch.out_time),
    .out_id       (out_ch.out_id),
    .out_last     (out_ch.last)
  );

endmodule

// File: design/mgsrt_dp.sv
module mgsrt_dp #(
  parameter int TABLE_DEPTH = mgsrt_pkg::TABLE_DEPTH
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [mgsrt_pkg::TIME_W-1:0]           cfg_wr_data,
  input  logic [mgsrt_pkg::TIME_W-1:0]           in_slot_time,
  input  logic [mgsrt_pkg::ID_W-1:0]             in_slot_id,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]       idx,
  input  mgsrt_pkg::cmd_t                        cmd,
  output mgsrt_pkg::stat_t                       stat,
  input  logic                                   out_ready,
  output logic                                   out_valid,
  output logic [mgsrt_pkg::STAT_W-1:0]           out_status,
  output logic [mgsrt_pkg::TIME_W-1:0]           out_time,
  output logic [mgsrt_pkg::ID_W-1:0]             out_id,
  output logic                                   out_last
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = $clog2(TABLE_DEPTH);

  logic [mgsrt_pkg::TIME_W-1:0] time_mem [TABLE_DEPTH];
  logic [mgsrt_pkg::ID_W-1:0]   id_mem   [TABLE_DEPTH];

  logic [mgsrt_pkg::TIME_W-1:0] sep_r, t_r, prev_r, carry_t_r, memq_t_r;
  logic [mgsrt_pkg::ID_W-1:0]   id_r, carry_id_r, memq_id_r;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [mgsrt_pkg::STAT_W-1:0] res_r;
  logic                         ov_r;
  logic [mgsrt_pkg::STAT_W-1:0] ostat_r;
  logic [mgsrt_pkg::TIME_W-1:0] otime_r;
  logic [mgsrt_pkg::ID_W-1:0]   oid_r;
  logic                         olast_r;

  logic [CW-1:0]                rd_sum, wr_sum;
  logic [IW-1:0]                rd_addr, wr_addr;
  logic [mgsrt_pkg::TIME_W-1:0] wr_t;
  logic [mgsrt_pkg::ID_W-1:0]   wr_id;
  logic [CW:0]                  idx_p1;

  assign rd_sum  = cmd.rd_next ? idx + CW'(1) : idx;
  assign wr_sum  = cmd.wr_prev ? idx - CW'(1) : idx;
  assign rd_addr = rd_sum[IW-1:0];
  assign wr_addr = wr_sum[IW-1:0];
  assign idx_p1  = {1'b0, idx} + (CW+1)'(1);

  always_comb begin
    unique case (cmd.wr_src)
      mgsrt_pkg::WSRC_NEW: begin
        wr_t  = t_r;
        wr_id = id_r;
      end
      mgsrt_pkg::WSRC_CARRY: begin
        wr_t  = carry_t_r;
        wr_id = carry_id_r;
      end
      mgsrt_pkg::WSRC_MEMQ: begin
        wr_t  = memq_t_r;
        wr_id = memq_id_r;
      end
      default: begin
        wr_t  = t_r;
        wr_id = id_r;
      end
    endcase
  end

  // table: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      time_mem[wr_addr] <= wr_t;
      id_mem[wr_addr]   <= wr_id;
    end
    memq_t_r  <= time_mem[rd_addr];
    memq_id_r <= id_mem[rd_addr];
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r <= mgsrt_pkg::SEP_RESET;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        sep_r <= cfg_wr_data;
      end
      cnt_r <= cnt_nxt;
      if (cmd.out_load) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      t_r    <= in_slot_time;
      id_r   <= in_slot_id;
      prev_r <= '0;
    end else if (cmd.prev_load) begin
      prev_r <= memq_t_r;
    end
    if (cmd.carry_load) begin
      carry_t_r  <= memq_t_r;
      carry_id_r <= memq_id_r;
    end
    if (cmd.res_load) begin
      res_r <= cmd.res_code;
    end
    if (cmd.out_load) begin
      if (cmd.out_entry) begin
        ostat_r <= mgsrt_pkg::ST_ENTRY;
        otime_r <= memq_t_r;
        oid_r   <= memq_id_r;
        olast_r <= (idx_p1 == {1'b0, cnt_r});
      end else begin
        ostat_r <= res_r;
        otime_r <= t_r;
        oid_r   <= '0;
        olast_r <= 1'b1;
      end
    end
  end

  // prev never exceeds t and a next entry is above t, so neither gap wraps
  assign stat.full          = (cnt_r == CW'(TABLE_DEPTH));
  assign stat.empty         = (cnt_r == '0);
  assign stat.at_end        = (idx == cnt_r);
  assign stat.is_last       = (idx_p1 == {1'b0, cnt_r});
  assign stat.le_t          = (memq_t_r <= t_r);
  assign stat.eq_t          = (memq_t_r == t_r);
  assign stat.gap_prev_fail = ((t_r - prev_r) < sep_r);
  assign stat.gap_next_fail = ((memq_t_r - t_r) < sep_r);
  assign stat.out_free      = !ov_r || out_ready;

  assign out_valid  = ov_r;
  assign out_status = ostat_r;
  assign out_time   = otime_r;
  assign out_id     = oid_r;
  assign out_last   = olast_r;

endmodule

// File: design/mgsrt_ctrl.sv
module mgsrt_ctrl #(
  parameter int TABLE_DEPTH = mgsrt_pkg::TABLE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic [mgsrt_pkg::ACT_W-1:0]        in_action,
  output logic                               in_ready,
  input  mgsrt_pkg::stat_t                   stat,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]   idx,
  output mgsrt_pkg::cmd_t                    cmd
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_REQ_SCAN  = 3'd1;
  localparam logic [2:0] S_REQ_SHIFT = 3'd2;
  localparam logic [2:0] S_WD_SCAN   = 3'd3;
  localparam logic [2:0] S_WD_SHIFT  = 3'd4;
  localparam logic [2:0] S_LIST      = 3'd5;
  localparam logic [2:0] S_RESP      = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt;

  assign idx      = idx_r;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_item = 1'b1;
          idx_nxt       = '0;
          unique case (in_action)
            mgsrt_pkg::ACT_REQUEST: begin
              if (stat.full) begin
                cmd.res_load = 1'b1;
                cmd.res_code = mgsrt_pkg::ST_FULL;
                state_nxt    = S_RESP;
              end else begin
                state_nxt = S_REQ_SCAN;
              end
            end
            mgsrt_pkg::ACT_WITHDRAW: state_nxt = S_WD_SCAN;
            mgsrt_pkg::ACT_LIST:     state_nxt = S_LIST;
            default:                 state_nxt = S_IDLE;
          endcase
        end
      end
      S_REQ_SCAN: begin
        cmd.res_load = 1'b1;
        if (stat.at_end) begin
          // no later slot: only the gap to the previous one matters
          if (stat.gap_prev_fail) begin
            cmd.res_code = mgsrt_pkg::ST_REJECTED;
          end else begin
            cmd.res_code = mgsrt_pkg::ST_ADMITTED;
            cmd.wr_en    = 1'b1;
            cmd.wr_src   = mgsrt_pkg::WSRC_NEW;
            cmd.cnt_inc  = 1'b1;
          end
          state_nxt = S_RESP;
        end else if (stat.le_t) begin
          cmd.res_load  = 1'b0;
          cmd.prev_load = 1'b1;
          cmd.rd_next   = 1'b1;
          idx_nxt       = idx_r + CW'(1);
        end else if (stat.gap_prev_fail || stat.gap_next_fail) begin
          cmd.res_code = mgsrt_pkg::ST_REJECTED;
          state_nxt    = S_RESP;
        end else begin
          // insert here, displaced entry rides up in the carry register
          cmd.res_load   = 1'b0;
          cmd.wr_en      = 1'b1;
          cmd.wr_src     = mgsrt_pkg::WSRC_NEW;
          cmd.carry_load = 1'b1;
          cmd.rd_next    = 1'b1;
          idx_nxt        = idx_r + CW'(1);
          state_nxt      = S_REQ_SHIFT;
        end
      end
      S_REQ_SHIFT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = mgsrt_pkg::WSRC_CARRY;
        if (stat.at_end) begin
          cmd.cnt_inc  = 1'b1;
          cmd.res_load = 1'b1;
          cmd.res_code = mgsrt_pkg::ST_ADMITTED;
          state_nxt    = S_RESP;
        end else begin
          cmd.carry_load = 1'b1;
          cmd.rd_next    = 1'b1;
          idx_nxt        = idx_r + CW'(1);
        end
      end
      S_WD_SCAN: begin
        if (stat.at_end) begin
          cmd.res_load = 1'b1;
          cmd.res_code = mgsrt_pkg::ST_NOTFOUND;
          state_nxt    = S_RESP;
        end else begin
          cmd.rd_next = 1'b1;
          idx_nxt     = idx_r + CW'(1);
          if (stat.eq_t) begin
            state_nxt = S_WD_SHIFT;
          end
        end
      end
      S_WD_SHIFT: begin
        if (stat.at_end) begin
          cmd.cnt_dec  = 1'b1;
          cmd.res_load = 1'b1;
          cmd.res_code = mgsrt_pkg::ST_WITHDRAWN;
          state_nxt    = S_RESP;
        end else begin
          cmd.wr_en   = 1'b1;
          cmd.wr_prev = 1'b1;
          cmd.wr_src  = mgsrt_pkg::WSRC_MEMQ;
          cmd.rd_next = 1'b1;
          idx_nxt     = idx_r + CW'(1);
        end
      end
      S_LIST: begin
        if (stat.empty) begin
          cmd.res_load = 1'b1;
          cmd.res_code = mgsrt_pkg::ST_EMPTY;
          state_nxt    = S_RESP;
        end else if (stat.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_entry = 1'b1;
          if (stat.is_last) begin
            idx_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            cmd.rd_next = 1'b1;
            idx_nxt     = idx_r + CW'(1);
          end
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          idx_nxt      = '0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        idx_nxt   = '0;
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// File: design/mgsrt_chk.sv
`include "min_gap_slot_reservation_table_defines.svh"

module mgsrt_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [mgsrt_pkg::ACT_W-1:0]    in_action,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [mgsrt_pkg::STAT_W-1:0]   out_status,
  input logic                           out_last
);

  logic item_real;

  assign item_real = (in_action == mgsrt_pkg::ACT_REQUEST) ||
                     (in_action == mgsrt_pkg::ACT_WITHDRAW) ||
                     (in_action == mgsrt_pkg::ACT_LIST);

  // a held result stays until taken
  `MGSRT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  // a real item closes the input after it is taken
  `MGSRT_ASSERT_NEXT(a_busy_after_item, clk, rst_n, in_valid && in_ready && item_real, !in_ready)
  // unused action code is dropped and the input stays open
  `MGSRT_ASSERT_NEXT(a_unused_idle, clk, rst_n, in_valid && in_ready && !item_real, in_ready)
  // only list entries may be non-final
  `MGSRT_ASSERT_SAME(a_single_last, clk, rst_n, out_valid && out_status != mgsrt_pkg::ST_ENTRY, out_last)

endmodule

bind min_gap_slot_reservation_table mgsrt_chk u_mgsrt_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_action  (in_ch.action),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_last   (out_ch.last)
);

// File: tb/sv/tb_min_gap_slot_reservation_table.sv
`timescale 1ns / 1ps

module tb_min_gap_slot_reservation_table;

  // Action code 3 is not decoded by the block: no result, no state change.
  localparam logic [mgsrt_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

  // Worst item is a full scan/shift over the table; margin on top of that.
  localparam int DRAIN_CYCLES = mgsrt_pkg::TABLE_DEPTH + 8;
  localparam int MAX_PAUSE    = 13;

  typedef struct {
    logic [mgsrt_pkg::ACT_W-1:0]  action;
    logic [mgsrt_pkg::TIME_W-1:0] slot_time;
    logic [mgsrt_pkg::ID_W-1:0]   slot_id;
  } slot_op_t;

  typedef struct {
    logic [mgsrt_pkg::STAT_W-1:0] status;
    logic [mgsrt_pkg::TIME_W-1:0] out_time;
    logic [mgsrt_pkg::ID_W-1:0]   out_id;
    logic                         last;
  } slot_reply_t;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_wr_en;
  logic [mgsrt_pkg::TIME_W-1:0] cfg_wr_data;

  mgsrt_in_if  in_if ();
  mgsrt_out_if out_if ();

  min_gap_slot_reservation_table DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the slot table: sorted times and ids, count, separation.
  // ---------------------------------------------------------------------------
  int                           m_sep;
  int                           m_count;
  logic [mgsrt_pkg::TIME_W-1:0] m_times [mgsrt_pkg::TABLE_DEPTH];
  logic [mgsrt_pkg::ID_W-1:0]   m_ids   [mgsrt_pkg::TABLE_DEPTH];

  slot_op_t    pending_ops[$];   // waiting for the driver
  slot_reply_t awaited[$];       // replies the block still owes, oldest first

  slot_op_t cur_op;              // op currently presented on in_if
  int       n_ops_in;
  int       n_replies;
  int       n_lists;
  int       n_seps;
  int       n_errors;

  // Apply one accepted op to the shadow table and queue the replies it causes.
  function automatic void model_slot_op(slot_op_t op);
    slot_reply_t r;
    int          pos;
    int          t;
    bit          gap_ok;
    t          = op.slot_time;
    r.status   = mgsrt_pkg::ST_ADMITTED;
    r.out_time = op.slot_time;
    r.out_id   = '0;
    r.last     = 1'b1;
    case (op.action)
      mgsrt_pkg::ACT_REQUEST: begin
        if (m_count >= mgsrt_pkg::TABLE_DEPTH) begin
          r.status = mgsrt_pkg::ST_FULL;
        end else begin
          // insertion point: after every slot with time <= t
          pos = 0;
          while (pos < m_count && int'(m_times[pos]) <= t) pos++;
          gap_ok = 1'b1;
          // first slot is measured from time zero
          if (pos == 0) gap_ok = (t >= m_sep);
          else if (t - int'(m_times[pos-1]) < m_sep) gap_ok = 1'b0;
          if (pos < m_count && int'(m_times[pos]) - t < m_sep) gap_ok = 1'b0;
          if (gap_ok) begin
            for (int i = m_count; i > pos; i--) begin
              m_times[i] = m_times[i-1];
              m_ids[i]   = m_ids[i-1];
            end
            m_times[pos] = op.slot_time;
            m_ids[pos]   = op.slot_id;
            m_count++;
          end else begin
            r.status = mgsrt_pkg::ST_REJECTED;
          end
        end
        awaited.push_back(r);
      end
      mgsrt_pkg::ACT_WITHDRAW: begin
        // earliest matching slot only
        pos = 0;
        while (pos < m_count && m_times[pos] != op.slot_time) pos++;
        if (pos >= m_count) begin
          r.status = mgsrt_pkg::ST_NOTFOUND;
        end else begin
          for (int i = pos; i + 1 < m_count; i++) begin
            m_times[i] = m_times[i+1];
            m_ids[i]   = m_ids[i+1];
          end
          m_count--;
          r.status = mgsrt_pkg::ST_WITHDRAWN;
        end
        awaited.push_back(r);
      end
      mgsrt_pkg::ACT_LIST: begin
        n_lists++;
        if (m_count == 0) begin
          r.status = mgsrt_pkg::ST_EMPTY;
          awaited.push_back(r);
        end else begin
          for (int i = 0; i < m_count; i++) begin
            r.status   = mgsrt_pkg::ST_ENTRY;
            r.out_time = m_times[i];
            r.out_id   = m_ids[i];
            r.last     = (i == m_count - 1);
            awaited.push_back(r);
          end
        end
      end
      default: ;  // unused code: nothing happens
    endcase
  endfunction

  function automatic int pick_pause(bit calm);
    return calm ? 0 : $urandom_range(0, MAX_PAUSE);
  endfunction

  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Driver: one op per transfer, random idle cycles between ops.
  // calm mode gives stretches with back-to-back ops.
  // ---------------------------------------------------------------------------
  int in_pause;
  bit in_calm;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_pause = 0;
      in_calm  = 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        model_slot_op(cur_op);
        n_ops_in++;
        if ($urandom_range(0, 11) == 0) in_calm = !in_calm;
        in_pause = pick_pause(in_calm);
      end
      // channel is free once the held op has transferred
      if (!in_if.valid || in_if.ready) begin
        if (in_pause > 0) begin
          in_pause--;
          in_if.valid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          cur_op = pending_ops.pop_front();
          in_if.valid     <= 1'b1;
          in_if.action    <= cur_op.action;
          in_if.slot_time <= cur_op.slot_time;
          in_if.slot_id   <= cur_op.slot_id;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks every result transfer against the oldest awaited reply,
  // then stalls ready for a random number of cycles.
  // ---------------------------------------------------------------------------
  int          out_pause;
  bit          out_calm;
  slot_reply_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_pause = 0;
      out_calm  = 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        n_replies++;
        if (awaited.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result, expected none actual status %0d time %0d id %0d",
                   $time, out_if.status, out_if.out_time, out_if.out_id);
        end else begin
          want = awaited.pop_front();
          compare_field("status", want.status, out_if.status);
          compare_field("out_time", want.out_time, out_if.out_time);
          compare_field("out_id", want.out_id, out_if.out_id);
          compare_field("last", want.last, out_if.last);
        end
        if ($urandom_range(0, 11) == 0) out_calm = !out_calm;
        out_pause = pick_pause(out_calm);
      end
      if (out_pause > 0) begin
        out_pause--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic void queue_op(logic [mgsrt_pkg::ACT_W-1:0] act, int t, int id);
    slot_op_t op;
    op.action    = act;
    op.slot_time = t[mgsrt_pkg::TIME_W-1:0];
    op.slot_id   = id[mgsrt_pkg::ID_W-1:0];
    pending_ops.push_back(op);
  endfunction

  // Wait until every op has transferred and every reply has arrived, then
  // let an unused-code op that produces nothing finish its pass.
  task automatic settle();
    do @(negedge clk);
    while (!(pending_ops.size() == 0 && !in_if.valid && awaited.size() == 0));
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write; caller has settled, so nothing is in flight.
  task automatic write_separation(int v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v[mgsrt_pkg::TIME_W-1:0];
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    m_sep = v;
    n_seps++;
  endtask

  // Withdraw every slot currently held (shadow is exact while settled).
  function automatic void clear_table();
    for (int i = 0; i < m_count; i++) queue_op(mgsrt_pkg::ACT_WITHDRAW, m_times[i], 0);
  endfunction

  // Mostly well-formed traffic: requests on a grid of the separation with a
  // one-tick jitter (hits the exact-gap boundary), withdraws of known times,
  // lists; the rest is uniform noise and the unused code.
  task automatic random_traffic(int n);
    int kmax;
    int t;
    int sel;
    int known[$];
    kmax = 65535 / (m_sep == 0 ? 1 : m_sep);
    if (kmax > 40) kmax = 40;
    for (int i = 0; i < m_count; i++) known.push_back(m_times[i]);
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        if ($urandom_range(0, 4) == 0) t = $urandom_range(0, 65535);
        else t = $urandom_range(0, kmax) * m_sep + $urandom_range(0, 2) - 1;
        if (t < 0) t = 0;
        if (t > 65535) t = 65535;
        known.push_back(t);
        queue_op(mgsrt_pkg::ACT_REQUEST, t, $urandom_range(0, 65535));
      end else if (sel < 80) begin
        if (known.size() != 0 && $urandom_range(0, 3) != 0)
          t = known[$urandom_range(0, known.size() - 1)];
        else
          t = $urandom_range(0, 65535);
        queue_op(mgsrt_pkg::ACT_WITHDRAW, t, $urandom_range(0, 65535));
      end else if (sel < 92) begin
        queue_op(mgsrt_pkg::ACT_LIST, $urandom_range(0, 65535), $urandom_range(0, 65535));
      end else begin
        queue_op(ACT_UNUSED, $urandom_range(0, 65535), $urandom_range(0, 65535));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    m_sep       = int'(mgsrt_pkg::SEP_RESET);
    m_count     = 0;
    n_ops_in    = 0;
    n_replies   = 0;
    n_lists     = 0;
    n_seps      = 0;
    n_errors    = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset separation (3): empty-table cases, boundaries at both ends of time.
    queue_op(mgsrt_pkg::ACT_LIST, 16'hFFFF, 16'hFFFF);    // empty list echoes time
    queue_op(mgsrt_pkg::ACT_WITHDRAW, 0, 16'hFFFF);       // withdraw on empty table
    queue_op(mgsrt_pkg::ACT_REQUEST, 0, 1);               // first slot too early
    queue_op(mgsrt_pkg::ACT_REQUEST, 2, 2);
    queue_op(mgsrt_pkg::ACT_REQUEST, 3, 16'hFFFF);        // exactly one separation
    queue_op(mgsrt_pkg::ACT_REQUEST, 5, 3);               // too close after
    queue_op(mgsrt_pkg::ACT_REQUEST, 6, 0);
    queue_op(mgsrt_pkg::ACT_REQUEST, 65535, 16'hAAAA);    // top of time range
    queue_op(mgsrt_pkg::ACT_REQUEST, 65533, 4);           // too close before
    queue_op(mgsrt_pkg::ACT_REQUEST, 65532, 16'h5555);    // exact gap on the next side
    queue_op(mgsrt_pkg::ACT_REQUEST, 4, 5);               // between, fails previous gap
    queue_op(ACT_UNUSED, 16'hFFFF, 16'hFFFF);             // ignored
    queue_op(mgsrt_pkg::ACT_WITHDRAW, 7, 0);              // unknown time
    queue_op(mgsrt_pkg::ACT_WITHDRAW, 6, 0);
    queue_op(mgsrt_pkg::ACT_LIST, 0, 0);
    queue_op(mgsrt_pkg::ACT_REQUEST, 9, 16'h1234);
    queue_op(mgsrt_pkg::ACT_LIST, 0, 0);
    settle();

    // Zero separation: equal times allowed, new one lands after its equals;
    // withdraw takes the earliest of the duplicates.
    write_separation(0);
    queue_op(mgsrt_pkg::ACT_REQUEST, 100, 1);
    queue_op(mgsrt_pkg::ACT_REQUEST, 100, 2);
    queue_op(mgsrt_pkg::ACT_REQUEST, 100, 3);
    queue_op(mgsrt_pkg::ACT_REQUEST, 0, 7);
    queue_op(mgsrt_pkg::ACT_REQUEST, 3, 9);
    queue_op(mgsrt_pkg::ACT_LIST, 0, 0);
    queue_op(mgsrt_pkg::ACT_WITHDRAW, 100, 0);
    queue_op(mgsrt_pkg::ACT_LIST, 0, 0);
    settle();

    // Maximum separation: only time 65535 fits in an empty table.
    write_separation(65535);
    clear_table();
    queue_op(mgsrt_pkg::ACT_REQUEST, 65534, 1);
    queue_op(mgsrt_pkg::ACT_REQUEST, 65535, 16'hFFFF);
    queue_op(mgsrt_pkg::ACT_REQUEST, 0, 2);
    queue_op(mgsrt_pkg::ACT_LIST, 0, 0);
    queue_op(mgsrt_pkg::ACT_WITHDRAW, 65535, 0);
    settle();

    // Random traffic over several settings.
    write_separation(5);
    random_traffic(25);
    settle();
    write_separation($urandom_range(1, 12));
    random_traffic(15);
    settle();
    write_separation($urandom_range(200, 4000));
    random_traffic(10);
    settle();

    // Separation 1: fill the table to capacity, then requests see full.
    write_separation(1);
    clear_table();
    settle();
    for (int i = 1; i <= mgsrt_pkg::TABLE_DEPTH + 1; i++)
      queue_op(mgsrt_pkg::ACT_REQUEST, i, i * 977);
    queue_op(mgsrt_pkg::ACT_REQUEST, 0, 16'hFFFF);        // full wins over gap check
    queue_op(mgsrt_pkg::ACT_LIST, 0, 0);                  // longest list
    queue_op(mgsrt_pkg::ACT_WITHDRAW, 65535, 0);
    settle();

    $display("Run covered %0d input transfers and %0d checked results, %0d lists,",
             n_ops_in, n_replies, n_lists);
    $display("over %0d separation writes plus the reset value; %0d mismatches.",
             n_seps, n_errors);
    if (n_errors == 0 && awaited.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
